// ----- design/lerect_pkg.sv -----
package lerect_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  // Reset value of the right and top edges: 1.0 in Q16.16.
  localparam int unsigned RECT_ONE = 65536;

  // The multiplier operand is cut into this many partial products.
  localparam int unsigned MUL_PARTS = 2;

  // Kind of line, decided from the two input points.
  typedef struct packed {
    logic vert;
    logic horz;
  } line_kind_t;

endpackage

// ----- design/lerect_in_if.sv -----
interface lerect_in_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] start_x;
  logic [W-1:0] start_y;
  logic [W-1:0] end_x;
  logic [W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ----- design/lerect_out_if.sv -----
interface lerect_out_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_start_x;
  logic [W-1:0] out_start_y;
  logic [W-1:0] out_end_x;
  logic [W-1:0] out_end_y;

  modport source (output valid, out_start_x, out_start_y, out_end_x, out_end_y, input ready);
  modport sink (input valid, out_start_x, out_start_y, out_end_x, out_end_y, output ready);
endinterface

// ----- design/lerect_regs.sv -----
module lerect_regs import lerect_pkg::*; #(
  parameter int W  = 32,
  parameter int DW = 32,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready,
  output logic [W-1:0]  left,
  output logic [W-1:0]  bottom,
  output logic [W-1:0]  right,
  output logic [W-1:0]  top
);

  logic [W-1:0] left_r, bottom_r, right_r, top_r;
  logic [W-1:0] rd_val;
  reg_idx_t     idx;
  logic         wr;

  assign idx    = reg_idx_t'(paddr[AW-1:AW-2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      bottom_r <= '0;
      right_r  <= W'(RECT_ONE);
      top_r    <= W'(RECT_ONE);
    end else if (wr) begin
      case (idx)
        REG_LEFT:   left_r   <= pwdata[W-1:0];
        REG_BOTTOM: bottom_r <= pwdata[W-1:0];
        REG_RIGHT:  right_r  <= pwdata[W-1:0];
        REG_TOP:    top_r    <= pwdata[W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEFT:   rd_val = left_r;
      REG_BOTTOM: rd_val = bottom_r;
      REG_RIGHT:  rd_val = right_r;
      REG_TOP:    rd_val = top_r;
      default:    rd_val = '0;
    endcase
  end

  assign prdata = DW'($signed(rd_val));
  assign left   = left_r;
  assign bottom = bottom_r;
  assign right  = right_r;
  assign top    = top_r;

endmodule

// ----- design/lerect_icpt.sv -----
module lerect_icpt import lerect_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] base,
  input  logic [W:0]   da,
  input  logic [W:0]   db,
  input  logic [W:0]   den,
  output logic [W-1:0] res
);

  // Computes base + (da*db)/den with a truncating quotient, saturated.
  // It has two multiply stages, W+1 divide stages and one sign-and-saturate
  // stage, all advanced together by en.
  localparam int H  = (W + 1) / MUL_PARTS;
  localparam int HI = W + 1 - H;
  localparam int PW = 2 * W + 2;
  localparam int LW = W + 1 + H;
  localparam int UW = W + 1 + HI;

  function automatic logic [W:0] mag(input logic [W:0] v);
    return v[W] ? (~v + 1'b1) : v;
  endfunction

  typedef struct packed {
    logic [W:0]   rem;
    logic [W:0]   low;
    logic [W:0]   q;
    logic [W:0]   d;
    logic         neg;
    logic         ovf;
    logic [W-1:0] base;
  } dv_t;

  logic [LW-1:0] pl_r;
  logic [UW-1:0] ph_r;
  logic [W:0]    d_r;
  logic          neg_r;
  logic [W-1:0]  base_r;
  logic [W:0]    ma, mb;
  logic [PW-1:0] prod;
  dv_t           dv_r [0:W+1];
  dv_t           dv0_nxt;
  logic [W+2:0]  sum;
  logic [W-1:0]  res_r, res_nxt;

  assign ma = mag(da);
  assign mb = mag(db);

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r   <= LW'(ma) * LW'(mb[H-1:0]);
      ph_r   <= UW'(ma) * UW'(mb[W:H]);
      d_r    <= mag(den);
      neg_r  <= (da[W] ^ db[W]) ^ den[W];
      base_r <= base;
    end
  end

  // A quotient of 2^(W+1) or more saturates whatever the base is.
  always_comb begin
    prod         = PW'(pl_r) + (PW'(ph_r) << H);
    dv0_nxt.rem  = prod[PW-1:W+1];
    dv0_nxt.low  = prod[W:0];
    dv0_nxt.q    = '0;
    dv0_nxt.d    = d_r;
    dv0_nxt.neg  = neg_r;
    dv0_nxt.ovf  = (prod[PW-1:W+1] >= d_r);
    dv0_nxt.base = base_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar k = 1; k <= W + 1; k++) begin : g_div
    logic [W+1:0] t;
    logic         ge;
    dv_t          st_nxt;
    always_comb begin
      t      = {dv_r[k-1].rem, dv_r[k-1].low[W]};
      ge     = (t >= {1'b0, dv_r[k-1].d});
      st_nxt = dv_r[k-1];
      st_nxt.rem = ge ? (t[W:0] - dv_r[k-1].d) : t[W:0];
      st_nxt.low = {dv_r[k-1].low[W-1:0], 1'b0};
      st_nxt.q   = {dv_r[k-1].q[W-1:0], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= st_nxt;
      end
    end
  end

  always_comb begin
    sum = $signed({{3{dv_r[W+1].base[W-1]}}, dv_r[W+1].base});
    if (dv_r[W+1].neg) begin
      sum = sum - {2'b00, dv_r[W+1].q};
    end else begin
      sum = sum + {2'b00, dv_r[W+1].q};
    end
    if (dv_r[W+1].ovf) begin
      res_nxt = dv_r[W+1].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if ((sum[W+2:W-1] != '0) && (sum[W+2:W-1] != '1)) begin
      res_nxt = sum[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res_nxt = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- design/line_extend_to_rectangle.sv -----
// Line extender: each input beat carries a line as two points in signed
// fixed point; the block stretches the line to the clipping rectangle held in
// four APB registers and returns the two fitted endpoints as one output beat.
// Vertical lines take the bottom and top edges, horizontal lines the left and
// right edges; other lines get four exact edge intercepts, truncated and
// saturated, and the edge pair is picked by strict comparisons (corner hits
// and misses pass through). One beat is accepted every clock cycle unless a
// finished beat waits on the output, which holds the whole pipeline. Each
// beat passes the input, difference, intercept and output registers; the
// one-bit-per-stage divider pipelines of the intercept units are most of it.
// Registers sit at byte addresses 4*i (8*i above 32 bits): left, bottom,
// right, top; change them only while the block is idle.
module line_extend_to_rectangle import lerect_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  lerect_in_if.sink    in_bus,
  lerect_out_if.source out_bus,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0]  cfg_paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] cfg_pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int AW  = (COORD_WIDTH > 32) ? 5 : 4;
  localparam int LAT = W + 4;

  typedef struct packed {
    logic [W-1:0] x1;
    logic [W-1:0] y1;
    logic [W-1:0] x2;
    logic [W-1:0] y2;
    line_kind_t   kind;
  } carry_t;

  logic [W-1:0] xl, yb, xr, yt;

  lerect_regs #(.W(W), .DW(DW), .AW(AW)) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .left    (xl),
    .bottom  (yb),
    .right   (xr),
    .top     (yt)
  );

  // Every stage moves together; the pipeline advances unless the output
  // register holds a beat that the sink does not take.
  logic adv;
  logic out_valid_r;

  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;

  // Input stage.
  logic         va_r;
  logic [W-1:0] ax1_r, ay1_r, ax2_r, ay2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r <= in_bus.start_x;
      ay1_r <= in_bus.start_y;
      ax2_r <= in_bus.end_x;
      ay2_r <= in_bus.end_y;
    end
  end

  // Difference stage: all differences are one bit wider than a coordinate.
  function automatic logic [W:0] sub(input logic [W-1:0] a, input logic [W-1:0] b);
    return {a[W-1], a} - {b[W-1], b};
  endfunction

  logic [W:0] dx_r, dy_r, dl_r, dr_r, db_r, dt_r;
  carry_t     car_r [0:LAT];
  logic       vl_r  [0:LAT];
  carry_t     car0_nxt;

  always_comb begin
    car0_nxt.x1        = ax1_r;
    car0_nxt.y1        = ay1_r;
    car0_nxt.x2        = ax2_r;
    car0_nxt.y2        = ay2_r;
    car0_nxt.kind.vert = (ax1_r == ax2_r);
    car0_nxt.kind.horz = (ay1_r == ay2_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r     <= sub(ax2_r, ax1_r);
      dy_r     <= sub(ay2_r, ay1_r);
      dl_r     <= sub(xl, ax1_r);
      dr_r     <= sub(xr, ax1_r);
      db_r     <= sub(yb, ay1_r);
      dt_r     <= sub(yt, ay1_r);
      car_r[0] <= car0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[0] <= 1'b0;
    end else if (adv) begin
      vl_r[0] <= va_r;
    end
  end

  // The line's points and kind ride alongside the intercept units.
  for (genvar k = 1; k <= LAT; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (adv) begin
        car_r[k] <= car_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k] <= 1'b0;
      end else if (adv) begin
        vl_r[k] <= vl_r[k-1];
      end
    end
  end

  // Four intercept units: y at the left and right edges, x at the bottom
  // and top edges. Their results line up with the last carry stage.
  logic [W-1:0] yl, yr, xb, xt;

  lerect_icpt #(.W(W)) u_yl (
    .clk(clk), .en(adv), .base(car_r[0].y1), .da(dy_r), .db(dl_r), .den(dx_r), .res(yl)
  );
  lerect_icpt #(.W(W)) u_yr (
    .clk(clk), .en(adv), .base(car_r[0].y1), .da(dy_r), .db(dr_r), .den(dx_r), .res(yr)
  );
  lerect_icpt #(.W(W)) u_xb (
    .clk(clk), .en(adv), .base(car_r[0].x1), .da(dx_r), .db(db_r), .den(dy_r), .res(xb)
  );
  lerect_icpt #(.W(W)) u_xt (
    .clk(clk), .en(adv), .base(car_r[0].x1), .da(dx_r), .db(dt_r), .den(dy_r), .res(xt)
  );

  // Edge selection and output register.
  logic         l_in, r_in, b_in, t_in;
  logic [W-1:0] ox1_nxt, oy1_nxt, ox2_nxt, oy2_nxt;
  logic [W-1:0] ox1_r, oy1_r, ox2_r, oy2_r;
  carry_t       c;

  assign c = car_r[LAT];

  always_comb begin
    l_in = ($signed(yl) > $signed(yb)) && ($signed(yl) < $signed(yt));
    r_in = ($signed(yr) > $signed(yb)) && ($signed(yr) < $signed(yt));
    b_in = ($signed(xb) > $signed(xl)) && ($signed(xb) < $signed(xr));
    t_in = ($signed(xt) > $signed(xl)) && ($signed(xt) < $signed(xr));
    ox1_nxt = c.x1;
    oy1_nxt = c.y1;
    ox2_nxt = c.x2;
    oy2_nxt = c.y2;
    if (c.kind.vert) begin
      oy1_nxt = yb;
      oy2_nxt = yt;
    end else if (c.kind.horz) begin
      ox1_nxt = xl;
      ox2_nxt = xr;
    end else if (l_in) begin
      ox1_nxt = xl;
      oy1_nxt = yl;
      if (t_in) begin
        ox2_nxt = xt;
        oy2_nxt = yt;
      end else if (b_in) begin
        ox2_nxt = xb;
        oy2_nxt = yb;
      end else begin
        ox2_nxt = xr;
        oy2_nxt = yr;
      end
    end else if (r_in) begin
      ox2_nxt = xr;
      oy2_nxt = yr;
      if (t_in) begin
        ox1_nxt = xt;
        oy1_nxt = yt;
      end else if (b_in) begin
        ox1_nxt = xb;
        oy1_nxt = yb;
      end
    end else if (t_in && b_in) begin
      ox1_nxt = xb;
      oy1_nxt = yb;
      ox2_nxt = xt;
      oy2_nxt = yt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vl_r[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox1_r <= ox1_nxt;
      oy1_r <= oy1_nxt;
      ox2_r <= ox2_nxt;
      oy2_r <= oy2_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.out_start_x = ox1_r;
  assign out_bus.out_start_y = oy1_r;
  assign out_bus.out_end_x   = ox2_r;
  assign out_bus.out_end_y   = oy2_r;

endmodule

// ----- design/lerect_chk.sv -----
module lerect_chk #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_start_x,
  input logic [W-1:0] out_end_y
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_start_x) && $stable(out_end_y))
    else $error("output payload changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind line_extend_to_rectangle lerect_chk #(.W(COORD_WIDTH)) u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_start_x (out_bus.out_start_x),
  .out_end_y   (out_bus.out_end_y)
);

// ----- bench/line_extend_to_rectangle_test.sv -----
`timescale 1ns / 100ps

module line_extend_to_rectangle_test import lerect_pkg::*;;

  localparam int CW = 32;
  localparam int LATENCY = CW + 6;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } seg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // APB configuration port; pready is always high, so a write needs no wait.
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [3:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  lerect_in_if #(.W(CW)) in_bus ();
  lerect_out_if #(.W(CW)) out_bus ();

  line_extend_to_rectangle #(.COORD_WIDTH(CW)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus.sink),
    .out_bus(out_bus.source),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // The bench keeps its own copy of the clipping rectangle as 64-bit signed
  // values so that intercept arithmetic never wraps before saturation.
  longint edge_left, edge_bottom, edge_right, edge_top;

  seg_t pending_lines[$];
  seg_t fitted_lines[$];

  // Idle probabilities, in percent, of the sender and the receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // While set, the receiver refuses every beat regardless of the odds.
  bit recv_hold = 1'b0;
  // Set when the input beat on the bus was taken at the last rising edge.
  bit in_taken = 1'b0;
  int error_count = 0;
  int lines_sent = 0;
  int lines_checked = 0;
  int watchdog = 0;

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // base + (da*db)/den with the quotient truncated toward zero. The product
  // needs up to 66 bits, so the division runs on 128-bit magnitudes, and the
  // quotient is capped at 2^62 before the sign is applied.
  function automatic longint edge_cross(longint base, longint da, longint db, longint den);
    logic [127:0] prod, quo, dmag, amag, bmag;
    logic neg;
    longint q;
    if (den == 0) return base;
    amag = (da < 0) ? -da : da;
    bmag = (db < 0) ? -db : db;
    dmag = (den < 0) ? -den : den;
    prod = amag * bmag;
    quo = prod / dmag;
    if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
    q = longint'(quo[63:0]);
    neg = ((da < 0) != (db < 0)) != (den < 0);
    return clamp_coord(neg ? base - q : base + q);
  endfunction

  function automatic seg_t fit_line(seg_t s);
    longint x1, y1, x2, y2, ox1, oy1, ox2, oy2, dx, dy;
    longint yl, yr, xb, xt;
    bit l_in, r_in, b_in, t_in;
    seg_t r;
    x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
    ox1 = x1; oy1 = y1; ox2 = x2; oy2 = y2;
    if (x1 == x2) begin
      // Vertical, and also the degenerate case of two identical points.
      oy1 = edge_bottom;
      oy2 = edge_top;
    end else if (y1 == y2) begin
      ox1 = edge_left;
      ox2 = edge_right;
    end else begin
      dx = x2 - x1;
      dy = y2 - y1;
      yl = edge_cross(y1, dy, edge_left - x1, dx);
      yr = edge_cross(y1, dy, edge_right - x1, dx);
      xb = edge_cross(x1, dx, edge_bottom - y1, dy);
      xt = edge_cross(x1, dx, edge_top - y1, dy);
      l_in = yl > edge_bottom && yl < edge_top;
      r_in = yr > edge_bottom && yr < edge_top;
      b_in = xb > edge_left && xb < edge_right;
      t_in = xt > edge_left && xt < edge_right;
      if (l_in) begin
        ox1 = edge_left; oy1 = yl;
        // Falls back to the right edge even when yr lies outside.
        if (t_in) begin
          ox2 = xt; oy2 = edge_top;
        end else if (b_in) begin
          ox2 = xb; oy2 = edge_bottom;
        end else begin
          ox2 = edge_right; oy2 = yr;
        end
      end else if (r_in) begin
        ox2 = edge_right; oy2 = yr;
        if (t_in) begin
          ox1 = xt; oy1 = edge_top;
        end else if (b_in) begin
          ox1 = xb; oy1 = edge_bottom;
        end
      end else if (t_in && b_in) begin
        ox1 = xb; oy1 = edge_bottom;
        ox2 = xt; oy2 = edge_top;
      end
      // Corner hits and misses leave both points untouched.
    end
    r.sx = ox1[CW-1:0]; r.sy = oy1[CW-1:0];
    r.ex = ox2[CW-1:0]; r.ey = oy2[CW-1:0];
    return r;
  endfunction

  // Driver: a new line is offered at the falling edge; a held beat stays put
  // until it is taken, so valid never drops while a beat is pending.
  initial begin
    in_bus.valid = 1'b0;
    in_bus.start_x = '0; in_bus.start_y = '0; in_bus.end_x = '0; in_bus.end_y = '0;
    out_bus.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_bus.valid || in_taken) begin
        if (pending_lines.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.valid <= 1'b1;
          {in_bus.start_x, in_bus.start_y, in_bus.end_x, in_bus.end_y} <= pending_lines[0];
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Input and output monitor: at each rising edge, an accepted input beat
  // gets its prediction queued and an accepted output beat is checked.
  always @(posedge clk) begin
    seg_t got, want, sent;
    bit took;
    int errs;
    if (rst_n) begin
      took = 1'b0;
      errs = 0;
      in_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        sent = {in_bus.start_x, in_bus.start_y, in_bus.end_x, in_bus.end_y};
        fitted_lines.push_back(fit_line(sent));
        void'(pending_lines.pop_front());
        lines_sent <= lines_sent + 1;
        took = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        took = 1'b1;
        got = {out_bus.out_start_x, out_bus.out_start_y, out_bus.out_end_x, out_bus.out_end_y};
        if (fitted_lines.size() == 0) begin
          $error("output beat with no line outstanding");
          errs = errs + 1;
        end else begin
          want = fitted_lines.pop_front();
          lines_checked <= lines_checked + 1;
          if (got.sx !== want.sx) begin
            $error("out_start_x expected %0d got %0d", want.sx, got.sx);
            errs = errs + 1;
          end
          if (got.sy !== want.sy) begin
            $error("out_start_y expected %0d got %0d", want.sy, got.sy);
            errs = errs + 1;
          end
          if (got.ex !== want.ex) begin
            $error("out_end_x expected %0d got %0d", want.ex, got.ex);
            errs = errs + 1;
          end
          if (got.ey !== want.ey) begin
            $error("out_end_y expected %0d got %0d", want.ey, got.ey);
            errs = errs + 1;
          end
        end
      end
      watchdog <= took ? 0 : watchdog + 1;
      error_count <= error_count + errs;
    end
  end

  // Watchdog: a run with no accepted beat for too long is declared hung.
  always @(posedge clk) begin
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // Register write over APB, setup then access, driven at falling edges.
  task automatic write_edge(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_LEFT: edge_left = longint'($signed(value));
      REG_BOTTOM: edge_bottom = longint'($signed(value));
      REG_RIGHT: edge_right = longint'($signed(value));
      default: edge_top = longint'($signed(value));
    endcase
  endtask

  task automatic set_rect(logic [31:0] l, logic [31:0] b, logic [31:0] r, logic [31:0] t);
    write_edge(REG_LEFT, l);
    write_edge(REG_BOTTOM, b);
    write_edge(REG_RIGHT, r);
    write_edge(REG_TOP, t);
  endtask

  // Waits until every queued line has been sent and answered, then lets the
  // pipeline settle before the rectangle may change.
  task automatic drain_all();
    while (pending_lines.size() > 0 || fitted_lines.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic add_line(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey);
    seg_t s;
    s.sx = sx; s.sy = sy; s.ex = ex; s.ey = ey;
    pending_lines.push_back(s);
  endtask

  // Random coordinate: mostly near the rectangle so that intercepts land on
  // the edges, sometimes fully random bits to reach saturation.
  function automatic logic [31:0] rand_coord(longint lo, longint hi);
    longint span, v;
    if ($urandom_range(9) < 2) return $urandom;
    span = hi - lo;
    if (span < 16) span = 16;
    v = lo - span / 2 + longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span + 1);
    return 32'(clamp_coord(v));
  endfunction

  task automatic random_lines(int count);
    logic [31:0] sx, sy, ex, ey;
    for (int i = 0; i < count; i++) begin
      sx = rand_coord(edge_left, edge_right);
      sy = rand_coord(edge_bottom, edge_top);
      ex = rand_coord(edge_left, edge_right);
      ey = rand_coord(edge_bottom, edge_top);
      // A share of vertical and horizontal lines.
      case ($urandom_range(9))
        0: ex = sx;
        1: ey = sy;
        default: ;
      endcase
      add_line(sx, sy, ex, ey);
    end
  endtask

  task automatic run_phase(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    random_lines(count);
    drain_all();
  endtask

  initial begin
    edge_left = 0; edge_bottom = 0; edge_right = RECT_ONE; edge_top = RECT_ONE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines against the reset rectangle (0..1.0 in both axes).
    add_line(32'h0000_8000, 32'h0000_0000, 32'h0000_8000, 32'h0000_4000);  // vertical
    add_line(32'h0000_1234, 32'h0000_1234, 32'h0000_1234, 32'h0000_1234);  // one point
    add_line(32'h0000_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_8000);  // horizontal
    add_line(32'h0000_2000, 32'h0000_4000, 32'h0000_4000, 32'h0000_6000);  // left to top
    add_line(32'h0000_2000, 32'h0000_C000, 32'h0000_4000, 32'h0000_A000);  // left to bottom
    add_line(32'h0000_2000, 32'h0000_4000, 32'h0000_4000, 32'h0000_4100);  // left to right
    add_line(32'h0000_C000, 32'h0000_2000, 32'h0000_E000, 32'h0000_6000);  // bottom to right
    add_line(32'h0000_C000, 32'h0000_E000, 32'h0000_E000, 32'h0000_A000);  // top to right
    add_line(32'h0000_7000, 32'h0000_2000, 32'h0000_8000, 32'h0000_4000);  // bottom to top
    add_line(32'h0000_0000, 32'h0000_0000, 32'h0000_4000, 32'h0000_4000);  // corner hit
    add_line(32'h0003_0000, 32'h0000_0000, 32'h0004_0000, 32'h0005_0000);  // miss
    add_line(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  // extremes
    add_line(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_line(32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF);  // saturates
    add_line(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    add_line(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    drain_all();

    // Extreme rectangles: the full range, and an inverted one.
    set_rect(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_line(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0003);
    add_line(32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 32'h0000_0001);
    add_line(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h0000_0000);
    drain_all();
    set_rect(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    add_line(32'h0000_4000, 32'h0000_2000, 32'h0000_8000, 32'h0000_9000);
    add_line(32'h0000_4000, 32'h0000_2000, 32'h0000_4000, 32'h0000_9000);
    drain_all();

    // Random phases across several rectangles and idling patterns.
    set_rect(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
    run_phase(250, 0, 0);
    set_rect(32'hFFF0_0000, 32'hFFE0_0000, 32'h0020_0000, 32'h0008_0000);
    run_phase(250, 83, 0);
    set_rect($urandom, $urandom, $urandom, $urandom);
    run_phase(100, 0, 0);
    set_rect(32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h0000_0010, 32'h0000_0020);
    run_phase(250, 0, 83);
    set_rect(32'hC000_0000, 32'hC000_0000, 32'h4000_0000, 32'h4000_0000);
    run_phase(250, 16, 16);

    // Back-pressure: the receiver stalls long enough that the pipeline fills
    // and the input stalls, while the sender keeps offering lines.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b1;
    random_lines(200);
    repeat (300) @(posedge clk);
    recv_hold = 1'b0;
    drain_all();

    repeat (LATENCY + 10) @(posedge clk);
    $display("lines sent %0d, lines checked %0d, over seven rectangles and four idle mixes",
             lines_sent, lines_checked);
    if (error_count == 0 && fitted_lines.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
